@@ rtl/core/lrgd_pkg.sv @@
// Package with the shared constants, types and helper function of the regression block.
package lrgd_pkg;
	localparam int MaxSamples = 1024;
	localparam int AddrW = $clog2(MaxSamples);
	localparam int CntW = AddrW + 1;
	localparam logic [31:0] OneQ16 = 32'h0001_0000;
	localparam logic [47:0] CostMax = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [0:0] {
		CFG_LEARNING_RATE = 1'b0,
		CFG_ITERATION_COUNT = 1'b1
	} cfg_index_t;

	typedef enum logic [0:0] {
		FUNC_LOAD = 1'b0,
		FUNC_PREDICT = 1'b1
	} func_t;

	typedef enum logic [0:0] {
		KIND_TRAINED = 1'b0,
		KIND_PREDICTION = 1'b1
	} kind_t;

	typedef struct packed {
		logic start;
		logic [CntW-1:0] count;
	} train_cmd_t;

	typedef struct packed {
		logic done;
		logic [31:0] intercept;
		logic [31:0] slope;
		logic [47:0] cost;
	} train_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		begin
			if (v > 66'sh0_7FFF_FFFF) begin
				r = 32'sh7FFF_FFFF;
			end else if (v < -66'sh0_8000_0000) begin
				r = -32'sh8000_0000;
			end else begin
				r = v[31:0];
			end
			return r;
		end
	endfunction
endpackage

@@ rtl/core/linear_regression_gradient_descent_top.sv @@
// Top level of the linear regression trainer with stream channels and a register port.
// Usage: items enter on s_axis (tuser = func, tlast = last_sample, tdata = {y, x}).
// A load item stores one sample while fewer than 1024 are held; no result
// follows unless it carries tlast. A load with tlast starts training on all stored
// samples; s_axis_tready stays low until the result is taken from m_axis.
// Training time is set by the shared multiplier loop over the sample memories
// and the 64-step serial divider, used twice per iteration and once for the cost.
// A predict item goes through the T_PRED multiply and T_OUT output register to m_axis.
// Results: m_axis_tuser = result_kind, tdata = {prediction, cost, slope, intercept}.
// The output register holds a result until m_axis_tready; no new item is
// taken while it is full. Reset clears the sample count, sets both
// parameters to 1.0 and the registers to 655 and 1500.
// Configuration writes use cfg_wr_en, cfg_index and cfg_data while idle.
module linear_regression_gradient_descent_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // sample_x [31:0], sample_y [63:32]
	input  logic         s_axis_tuser,  // func
	input  logic         s_axis_tlast,  // last_sample
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata,  // intercept_out, slope_out, final_cost, prediction
	output logic         m_axis_tuser   // result_kind
);
	import lrgd_pkg::*;

	typedef enum logic [1:0] {T_IDLE, T_PRED, T_TRAIN, T_OUT} top_state_t;

	top_state_t         state_q;
	logic [15:0]        lr_q, itc_q;
	logic [CntW-1:0]    count_q;
	logic signed [31:0] t0_q, t1_q, qx_q;
	logic signed [63:0] pprod_q;
	logic               accept, is_load;
	train_cmd_t         cmd;
	train_rsp_t         rsp;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign is_load = s_axis_tuser == FUNC_LOAD;
	assign s_axis_tready = (state_q == T_IDLE);

	always_comb begin
		cmd.start = accept && is_load && s_axis_tlast;
		cmd.count = (count_q < CntW'(MaxSamples)) ? count_q + 1'b1 : count_q;
	end

	lrgd_train u_train (
		.clk(clk), .arst_n(arst_n),
		.wr_en(accept && is_load && count_q < CntW'(MaxSamples)),
		.wr_addr(count_q[AddrW-1:0]),
		.wr_x(s_axis_tdata[31:0]), .wr_y(s_axis_tdata[63:32]),
		.learning_rate(lr_q), .iteration_count(itc_q),
		.cmd(cmd), .rsp(rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			lr_q <= 16'd655;
			itc_q <= 16'd1500;
			count_q <= '0;
			t0_q <= OneQ16;
			t1_q <= OneQ16;
			m_axis_tvalid <= 1'b0;
			m_axis_tuser <= KIND_TRAINED;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == CFG_LEARNING_RATE) lr_q <= cfg_data;
				else lr_q <= lr_q;
				if (cfg_index == CFG_ITERATION_COUNT) itc_q <= cfg_data;
			end
			case (state_q)
				T_IDLE: if (accept) begin
					if (!is_load) begin
						qx_q <= s_axis_tdata[31:0];
						state_q <= T_PRED;
					end else begin
						if (count_q < CntW'(MaxSamples)) count_q <= count_q + 1'b1;
						if (s_axis_tlast) begin
							state_q <= T_TRAIN;
							count_q <= '0;
						end
					end
				end
				T_PRED: begin
					pprod_q <= 64'(qx_q * t1_q);
					state_q <= T_OUT;
				end
				T_TRAIN: if (rsp.done) begin
					t0_q <= rsp.intercept;
					t1_q <= rsp.slope;
					m_axis_tdata <= {32'd0, rsp.cost, rsp.slope, rsp.intercept};
					m_axis_tuser <= KIND_TRAINED;
					m_axis_tvalid <= 1'b1;
					state_q <= T_OUT;
				end
				T_OUT: begin
					if (!m_axis_tvalid) begin
						m_axis_tdata <= {sat32(66'(t0_q) + 66'(pprod_q >>> 16)), 112'd0};
						m_axis_tuser <= KIND_PREDICTION;
						m_axis_tvalid <= 1'b1;
					end else if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while a result is pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_load && s_axis_tlast) |=> count_q == '0)
		else $error("sample count not cleared by training");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CntW'(MaxSamples))
		else $error("sample count overflow");
endmodule

@@ rtl/core/lrgd_div.sv @@
// Iterative restoring divider for a signed 64-bit dividend by an unsigned divisor.
module lrgd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] dividend,
	input  logic [12:0]        divisor,
	output logic               done,
	output logic signed [63:0] quotient
);
	import lrgd_pkg::*;

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [12:0] dvs_q;
	logic        neg_q;
	logic [6:0]  step_q;
	logic        busy_q;
	logic [13:0] trial;
	logic [64:0] shifted;

	assign shifted = {rem_q[63:0], quo_q[63]};
	assign trial = shifted[13:0] - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 7'd1;
				if (step_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[63] ? 64'(-dividend) : dividend;
			neg_q <= dividend[63];
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[13] && shifted[64:14] == '0) begin
				rem_q <= {50'd0, trial};
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

@@ rtl/core/lrgd_train.sv @@
// Training sequencer: sample stores and one shared multiplier walked over all samples.
module lrgd_train (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [lrgd_pkg::AddrW-1:0]       wr_addr,
	input  logic signed [31:0]               wr_x,
	input  logic signed [31:0]               wr_y,
	input  logic [15:0]                      learning_rate,
	input  logic [15:0]                      iteration_count,
	input  lrgd_pkg::train_cmd_t             cmd,
	output lrgd_pkg::train_rsp_t             rsp
);
	import lrgd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_MUL_H, S_ERR, S_MUL_E, S_ACC, S_DIV_E, S_DIV_X,
		S_UPD_0, S_UPD_1, S_UPD_2, S_UPD_3, S_DIV_C, S_DONE
	} state_t;

	logic signed [31:0] feat_mem [MaxSamples];
	logic signed [31:0] targ_mem [MaxSamples];
	logic signed [31:0] fx_q, fy_q;

	state_t             state_q;
	logic [CntW-1:0]    m_q;
	logic [CntW-1:0]    j_q;
	logic [15:0]        it_q;
	logic               cost_pass_q;
	logic signed [31:0] t0_q, t1_q;
	logic signed [63:0] se_q, sex_q, mean_e_q;
	logic [63:0]        sc_q;
	logic signed [31:0] e_q;
	logic signed [63:0] prod_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic               div_start;
	logic signed [63:0] div_num;
	logic [12:0]        div_den;
	logic               div_done;
	logic signed [63:0] div_quo;
	logic [47:0]        cost_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			feat_mem[wr_addr] <= wr_x;
			targ_mem[wr_addr] <= wr_y;
		end
		fx_q <= feat_mem[j_q[AddrW-1:0]];
		fy_q <= targ_mem[j_q[AddrW-1:0]];
	end

	// The mean of e times x needs up to 48 bits, so its step product is taken in two halves.
	always_comb begin
		mul_a = {fx_q[31], fx_q};
		mul_b = {t1_q[31], t1_q};
		case (state_q)
			S_MUL_E: begin
				mul_a = {e_q[31], e_q};
				mul_b = cost_pass_q ? {e_q[31], e_q} : {fx_q[31], fx_q};
			end
			S_UPD_0: begin
				mul_a = {17'd0, learning_rate};
				mul_b = 33'(mean_e_q);
			end
			S_UPD_1: begin
				mul_a = {17'd0, learning_rate};
				mul_b = {9'd0, sex_q[23:0]};
			end
			S_UPD_2: begin
				mul_a = {17'd0, learning_rate};
				mul_b = {{9{sex_q[47]}}, sex_q[47:24]};
			end
			default: ;
		endcase
		mul_p = 66'(mul_a * mul_b);
	end

	assign div_num = (state_q == S_DIV_C) ? $signed(sc_q) : (state_q == S_DIV_X ? sex_q : se_q);
	assign div_den = (state_q == S_DIV_C) ? 13'({m_q, 1'b0}) : 13'(m_q);

	lrgd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .done(div_done), .quotient(div_quo)
	);

	logic div_busy_q;
	assign div_start = (state_q == S_DIV_E || state_q == S_DIV_X || state_q == S_DIV_C)
		&& !div_busy_q && !div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_busy_q <= 1'b0;
			t0_q <= OneQ16;
			t1_q <= OneQ16;
			m_q <= '0;
			j_q <= '0;
			it_q <= '0;
			cost_pass_q <= 1'b0;
			rsp <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (div_start) div_busy_q <= 1'b1;
			if (div_done) div_busy_q <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.start) begin
					m_q <= cmd.count;
					t0_q <= OneQ16;
					t1_q <= OneQ16;
					it_q <= '0;
					j_q <= '0;
					se_q <= '0;
					sex_q <= '0;
					sc_q <= '0;
					cost_pass_q <= (iteration_count == 16'd0);
					state_q <= S_READ;
				end
				S_READ: state_q <= S_MUL_H;
				S_MUL_H: begin
					prod_q <= mul_p[63:0];
					state_q <= S_ERR;
				end
				S_ERR: begin
					e_q <= sat32(66'(t0_q) + 66'(prod_q >>> 16) - 66'(fy_q));
					state_q <= S_MUL_E;
				end
				S_MUL_E: begin
					prod_q <= mul_p[63:0];
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (cost_pass_q) begin
						sc_q <= sc_q + 64'(prod_q >>> 16);
					end else begin
						se_q <= se_q + 64'(e_q);
						sex_q <= sex_q + (prod_q >>> 16);
					end
					j_q <= j_q + 1'b1;
					if (j_q + 1'b1 == m_q) begin
						j_q <= '0;
						state_q <= cost_pass_q ? S_DIV_C : S_DIV_E;
					end else begin
						state_q <= S_READ;
					end
				end
				S_DIV_E: if (div_done) begin
					mean_e_q <= div_quo;
					state_q <= S_DIV_X;
				end
				S_DIV_X: if (div_done) begin
					sex_q <= div_quo;
					state_q <= S_UPD_0;
				end
				S_UPD_0: begin
					prod_q <= mul_p[63:0];
					state_q <= S_UPD_1;
				end
				S_UPD_1: begin
					t0_q <= sat32(66'(t0_q) - 66'(prod_q >>> 16));
					prod_q <= mul_p[63:0];
					state_q <= S_UPD_2;
				end
				S_UPD_2: begin
					prod_q <= prod_q + (mul_p[63:0] << 24);
					state_q <= S_UPD_3;
				end
				S_UPD_3: begin
					t1_q <= sat32(66'(t1_q) - 66'(prod_q >>> 16));
					se_q <= '0;
					sex_q <= '0;
					it_q <= it_q + 16'd1;
					if (it_q + 16'd1 == iteration_count) cost_pass_q <= 1'b1;
					state_q <= S_READ;
				end
				S_DIV_C: if (div_done) begin
					cost_q <= (div_quo[63:48] != '0) ? CostMax : div_quo[47:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					rsp.done <= 1'b1;
					rsp.intercept <= t0_q;
					rsp.slope <= t1_q;
					rsp.cost <= cost_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) rsp.done |-> $past(state_q) == S_DONE)
		else $error("training result without finishing");
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> !div_start)
		else $error("divider restarted on completion");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> j_q < m_q)
		else $error("sample index beyond count");
endmodule
